FILE: rtl/core/aabb_pkg.sv
// ----------------------------------------------------------------------------
// AABB package
// Request and result types, opcodes and fixed-point limits.
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int CoordW = 32;
  localparam int DistW  = 48;
  localparam int NumW   = 49;  // |diff| * 65536 magnitude: 33 + 16 bits
  localparam int MagW   = 32;  // |dir| magnitude

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_TEST  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic        [1:0]        opcode;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DistW-1:0] t_enter;
    logic signed [DistW-1:0] t_exit;
  } res_t;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [DistW-1:0]  DistMax  = {1'b0, {(DistW-1){1'b1}}};
  localparam logic signed [DistW-1:0]  DistMin  = {1'b1, {(DistW-1){1'b0}}};

endpackage

FILE: rtl/core/aabb_build_and_ray_slab_test.sv
// ----------------------------------------------------------------------------
// AABB build and ray slab test
// Holds one box; clear, add-vertex and ray slab test requests.
// ----------------------------------------------------------------------------
// Clear and add requests update the box from idle and leave busy low. A
// test request runs six slab divisions through one shared bit-serial
// divider, each with a load step before it and a fold step after it; a zero
// direction component skips both divisions of its axis and folds in distance
// zero. busy stays high meanwhile. The result appears for one cycle with
// valid high and cannot be held off by the receiver.
module aabb_build_and_ray_slab_test
  import aabb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic valid,
  output res_t res
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_WAIT, S_DONE} state_t;

  state_t state;
  logic signed [CoordW-1:0] bmin [3];
  logic signed [CoordW-1:0] bmax [3];
  req_t        cur;
  logic [2:0]  step;          // slab index: axis*2 + (0 min, 1 max)
  logic signed [DistW-1:0] a_dist;
  logic signed [DistW-1:0] enter, exit_;

  logic        [1:0]        ax;
  logic signed [CoordW-1:0] bnd, org, dv;
  logic signed [CoordW:0]   dif;
  logic                     neg;
  logic        [NumW-1:0]   num;
  logic        [MagW-1:0]   den;
  logic                     go, done;
  logic        [NumW-1:0]   quo;
  logic signed [DistW-1:0]  q_sat, q_in, lo, hi;
  logic                     fold_now;

  assign ax = step[2:1];

  always_comb begin
    case (ax)
      2'd0: begin org = cur.px; dv = cur.dir_x; end
      2'd1: begin org = cur.py; dv = cur.dir_y; end
      default: begin org = cur.pz; dv = cur.dir_z; end
    endcase
    bnd = step[0] ? bmax[ax] : bmin[ax];
    dif = (CoordW+1)'(bnd) - (CoordW+1)'(org);
    neg = dif[CoordW] ^ dv[CoordW-1];
    num = {(dif[CoordW] ? (CoordW+1)'(-dif) : dif), 16'd0};
    den = dv[CoordW-1] ? MagW'(-dv) : MagW'(dv);
  end

  assign go = (state == S_LOAD) && (dv != '0);

  aabb_div u_div (
    .clk (clk), .rst (rst), .go (go), .num (num), .den (den),
    .done(done), .quo (quo)
  );

  // saturate the magnitude, then apply the sign
  always_comb begin
    if (neg) q_sat = (quo > NumW'(DistW'(1) << (DistW-1))) ? DistMin
                     : DistW'(-quo);
    else     q_sat = (quo > NumW'(DistMax)) ? DistMax : DistW'(quo);
    // a zero direction folds in distance zero straight from the load cycle
    q_in = (state == S_WAIT) ? q_sat : '0;
    lo = (a_dist < q_in) ? a_dist : q_in;
    hi = (a_dist < q_in) ? q_in : a_dist;
  end

  assign fold_now = ((state == S_LOAD) && (dv == '0)) || ((state == S_WAIT) && done);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        bmin[i] <= CoordMax;
        bmax[i] <= CoordMin;
      end
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= req;
            case (op_t'(req.opcode))
              OP_CLEAR: begin
                for (int i = 0; i < 3; i++) begin
                  bmin[i] <= CoordMax;
                  bmax[i] <= CoordMin;
                end
              end
              OP_ADD: begin
                if (req.px < bmin[0]) bmin[0] <= req.px;
                if (req.px > bmax[0]) bmax[0] <= req.px;
                if (req.py < bmin[1]) bmin[1] <= req.py;
                if (req.py > bmax[1]) bmax[1] <= req.py;
                if (req.pz < bmin[2]) bmin[2] <= req.pz;
                if (req.pz > bmax[2]) bmax[2] <= req.pz;
              end
              OP_TEST: begin
                state <= S_LOAD;
                step  <= '0;
                enter <= DistMin;
                exit_ <= DistMax;
              end
              default: ;
            endcase
          end
        end
        S_LOAD, S_WAIT: begin
          if (fold_now) begin
            // hold the min-bound distance, combine on the max-bound one
            if (!step[0]) begin
              a_dist <= q_in;
            end else begin
              if (lo > enter) enter <= lo;
              if (hi < exit_) exit_ <= hi;
            end
            step  <= step + 3'd1;
            state <= (step == 3'd5) ? S_DONE : S_LOAD;
          end else if (state == S_LOAD) begin
            state <= S_WAIT;
          end
        end
        S_DONE: begin
          valid       <= 1'b1;
          res.hit     <= (exit_ >= enter) && !exit_[DistW-1];
          res.t_enter <= enter;
          res.t_exit  <= exit_;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/aabb_div.sv
// ----------------------------------------------------------------------------
// AABB serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aabb_div
  import aabb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [NumW-1:0] num,
  input  logic [MagW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quo
);

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] shf;
  logic [MagW:0]   rem;
  logic [MagW-1:0] dvs;
  logic [CntW-1:0] cnt;
  logic            run;
  logic [MagW:0]   trial;
  logic [MagW:0]   diff;

  assign trial = {rem[MagW-1:0], shf[NumW-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CntW'(NumW);
        shf <= num;
        dvs <= den;
        rem <= '0;
        quo <= '0;
      end else if (run) begin
        shf <= shf << 1;
        if (!diff[MagW]) begin
          rem <= diff;
          quo <= {quo[NumW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/aabb_checker.sv
// ----------------------------------------------------------------------------
// AABB port checker
// Assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module aabb_checker
  import aabb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input req_t req,
  input logic busy,
  input logic valid,
  input res_t res
);

  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy)) else $error("result without work");

  a_valid_pulse: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid) else $error("result longer than one cycle");

  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.opcode == OP_TEST) |=> busy)
    else $error("test request not taken");

  a_add_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.opcode != OP_TEST) |=> !busy)
    else $error("box update stalled");

  a_hit: assert property (@(posedge clk) disable iff (rst)
    (valid && res.hit) |-> (res.t_exit >= res.t_enter && !res.t_exit[DistW-1]))
    else $error("hit inconsistent");

endmodule

bind aabb_build_and_ray_slab_test aabb_checker u_aabb_checker (.*);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// AABB build and ray slab test bench
// Drives clear, add-vertex and ray-test requests with random gaps and
// checks every result against an in-bench box model and slab predictor.
// ----------------------------------------------------------------------------
module tb;
  import aabb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 700;
  localparam longint CycleLimit = 64'd2_000_000;

  class slab_scoreboard;
    logic signed [CoordW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    res_t pending[$];
    int errors;

    function new();
      empty_box();
      errors = 0;
    endfunction

    function void empty_box();
      lo_x = CoordMax; lo_y = CoordMax; lo_z = CoordMax;
      hi_x = CoordMin; hi_y = CoordMin; hi_z = CoordMin;
    endfunction

    function longint slab(logic signed [CoordW-1:0] bound, logic signed [CoordW-1:0] org,
                          logic signed [CoordW-1:0] d);
      longint num, q;
      if (d == 0) return 0;
      num = (longint'(bound) - longint'(org)) * 65536;
      q = num / longint'(d);
      if (q > longint'(DistMax)) q = DistMax;
      if (q < longint'(DistMin)) q = DistMin;
      return q;
    endfunction

    function void fold(logic signed [CoordW-1:0] lo, logic signed [CoordW-1:0] hi,
                       logic signed [CoordW-1:0] o, logic signed [CoordW-1:0] d,
                       inout longint t_in, inout longint t_out);
      longint a, b;
      a = slab(lo, o, d);
      b = slab(hi, o, d);
      if ((a < b ? a : b) > t_in) t_in = a < b ? a : b;
      if ((a > b ? a : b) < t_out) t_out = a > b ? a : b;
    endfunction

    function void note_request(req_t r);
      longint t_in, t_out;
      res_t e;
      case (op_t'(r.opcode))
        OP_CLEAR: empty_box();
        OP_ADD: begin
          if (r.px < lo_x) lo_x = r.px;
          if (r.px > hi_x) hi_x = r.px;
          if (r.py < lo_y) lo_y = r.py;
          if (r.py > hi_y) hi_y = r.py;
          if (r.pz < lo_z) lo_z = r.pz;
          if (r.pz > hi_z) hi_z = r.pz;
        end
        OP_TEST: begin
          t_in = DistMin;
          t_out = DistMax;
          fold(lo_x, hi_x, r.px, r.dir_x, t_in, t_out);
          fold(lo_y, hi_y, r.py, r.dir_y, t_in, t_out);
          fold(lo_z, hi_z, r.pz, r.dir_z, t_in, t_out);
          e.hit = (t_out >= t_in) && (t_out >= 0);
          e.t_enter = t_in[DistW-1:0];
          e.t_exit = t_out[DistW-1:0];
          pending.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) report($sformatf("hit got %0b exp %0b", got.hit, e.hit));
      if (got.t_enter !== e.t_enter)
        report($sformatf("t_enter got %h exp %h", got.t_enter, e.t_enter));
      if (got.t_exit !== e.t_exit)
        report($sformatf("t_exit got %h exp %h", got.t_exit, e.t_exit));
    endfunction

    function void report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endfunction
  endclass

  logic clk, rst, start, busy, valid;
  req_t req;
  res_t res;
  longint cycles;
  bit calm;
  slab_scoreboard sb;

  aabb_build_and_ray_slab_test i_dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .valid(valid), .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cycles = 0;
    calm = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst && valid) sb.check_result(res);
  end

  // hold start until the request is taken, then optionally idle
  task automatic send(req_t r);
    req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    if (!calm && $urandom_range(99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(9))
      0: return CoordMax;
      1: return CoordMin;
      2: return 32'd0;
      3, 4, 5: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t mk(op_t op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    req_t r;
    r.opcode = op;
    r.px = x; r.py = y; r.pz = z;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    return r;
  endfunction

  function automatic req_t rand_req(op_t op);
    return mk(op, coord(), coord(), coord(), coord(), coord(), coord());
  endfunction

  initial begin
    int n;
    op_t op;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty box, then a unit box with axis-aligned, zero and extreme directions
    send(mk(OP_TEST, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000));
    send(mk(OP_NONE, 5, 5, 5, 1, 1, 1));
    send(mk(OP_ADD, 0, 0, 0, 0, 0, 0));
    send(mk(OP_ADD, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0));
    send(mk(OP_NONE, CoordMax, CoordMin, 0, 0, 0, 0));
    send(mk(OP_TEST, 32'hFFFF0000, 32'h8000, 32'h8000, 32'h10000, 0, 0));
    send(mk(OP_TEST, 32'h8000, 32'h8000, 32'h8000, 0, 0, 0));
    send(mk(OP_TEST, 32'h30000, 32'h30000, 32'h30000, 32'hFFFF0000, 32'hFFFF0000,
            32'hFFFF0000));
    send(mk(OP_TEST, 32'h30000, 32'h8000, 32'h8000, 32'h10000, 0, 0));
    send(mk(OP_TEST, CoordMin, CoordMin, CoordMin, 1, 1, 1));
    send(mk(OP_TEST, CoordMax, CoordMax, CoordMax, 32'hFFFFFFFF, CoordMin, CoordMax));
    send(mk(OP_ADD, CoordMin, CoordMax, CoordMin, 0, 0, 0));
    send(mk(OP_ADD, CoordMax, CoordMin, CoordMax, 0, 0, 0));
    send(mk(OP_TEST, CoordMin, CoordMax, 0, 1, CoordMin, 32'hFFFFFFFF));
    send(mk(OP_TEST, 0, 0, 0, CoordMax, 1, CoordMin));
    send(mk(OP_CLEAR, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax));
    send(mk(OP_TEST, 0, 0, 0, 0, 32'hFFFFFFFF, 1));

    // well-formed clear/add.../test sequences, with some noise
    n = 0;
    while (n < NumRandom) begin
      calm = (n > 300 && n < 400);
      if ($urandom_range(9) == 0) begin
        op = op_t'($urandom_range(3));
        send(rand_req(op));
        if (op != OP_NONE) n++;
      end else begin
        send(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        repeat ($urandom_range(4, 1)) send(rand_req(OP_ADD));
        repeat ($urandom_range(3, 1)) send(rand_req(OP_TEST));
        n += 6;
      end
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/aabb_pkg.sv
rtl/core/aabb_div.sv
rtl/core/aabb_build_and_ray_slab_test.sv
rtl/core/aabb_checker.sv
dv/tb.sv
